FILE: hw/rtl/stbg_pkg.sv
// Shared constants, types and the quarter-wave sine table builder for the tone burst generator.
`timescale 1ns / 1ps

package stbg_pkg;

    // Block configuration
    localparam int SAMPLE_RATE = 16000;
    localparam int MAX_SAMPLES = 4096;
    localparam int PHASE_BITS  = 32;
    localparam int TABLE_BITS  = 10;

    // Item field widths
    localparam int FREQ_W = 16;
    localparam int MS_W   = 16;
    localparam int DAC_W  = 10;

    // Item function codes
    localparam logic FUNC_START = 1'b0;
    localparam logic FUNC_TICK  = 1'b1;

    localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
    localparam int RATE_W = $clog2(SAMPLE_RATE);

    // Phase step = freq * STEP_INT + floor(freq * STEP_REM / SAMPLE_RATE), mod 2^PHASE_BITS
    localparam longint unsigned PHASE_MOD = 64'd1 << PHASE_BITS;
    localparam longint unsigned STEP_INT  = PHASE_MOD / SAMPLE_RATE;
    localparam longint unsigned STEP_REM  = PHASE_MOD % SAMPLE_RATE;
    localparam logic [PHASE_BITS-1:0] STEP_INT_C = PHASE_BITS'(STEP_INT);

    // Division of freq * STEP_REM by the sample rate: multiply by a rounded-up reciprocal
    localparam int SX_W  = FREQ_W + RATE_W;
    localparam int SX_S  = SX_W + RATE_W;
    localparam int SXM_W = SX_S - RATE_W + 2;
    localparam longint unsigned SX_M = ((64'd1 << SX_S) + SAMPLE_RATE - 1) / SAMPLE_RATE;
    localparam logic [SX_W-1:0]  STEP_REM_C = SX_W'(STEP_REM);
    localparam logic [SXM_W-1:0] SX_M_C     = SXM_W'(SX_M);

    // Sample count = ms * SAMPLE_RATE / 1000, same reciprocal trick
    localparam int MS_PER_S = 1000;
    localparam int MSD_W    = $clog2(MS_PER_S);
    localparam int CY_W     = MS_W + RATE_W + 1;
    localparam int CY_S     = CY_W + MSD_W;
    localparam int CYM_W    = CY_S - MSD_W + 2;
    localparam int CQ_W     = CY_W - MSD_W + 1;
    localparam longint unsigned CY_M = ((64'd1 << CY_S) + MS_PER_S - 1) / MS_PER_S;
    localparam logic [CY_W-1:0]  RATE_C = CY_W'(SAMPLE_RATE);
    localparam logic [CYM_W-1:0] CY_M_C = CYM_W'(CY_M);

    // DAC codes
    localparam logic [DAC_W-1:0] DAC_MID = DAC_W'(1 << (DAC_W - 1));
    localparam logic [DAC_W-1:0] DAC_MAX = DAC_W'((1 << DAC_W) - 1);

    // Quarter-wave table: {inexact, floor(512*sin)} per entry
    localparam int QTR_BITS = TABLE_BITS - 2;
    localparam int QTR_SIZE = 1 << QTR_BITS;
    localparam int MAG_W    = DAC_W - 1;
    localparam int QTR_W    = MAG_W + 1;
    localparam int FRAC_SH  = 62 - MAG_W;
    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef logic [QTR_SIZE-1:0][QTR_W-1:0] t_qtr_tbl;

    // Start item operands, partly multiplied out on entry
    typedef struct packed {
        logic [PHASE_BITS-1:0] step_int;
        logic [SX_W-1:0]       frac_num;
        logic [CY_W-1:0]       cnt_num;
    } t_tone_prep;

    // (a*b) >> 62 in Q2.62, product below 4.0
    function automatic logic [63:0] mul_q62(logic [63:0] a, logic [63:0] b);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        return p[125:62];
    endfunction

    // floor(a / d) by restoring long division; only evaluated while the table is built
    function automatic logic [63:0] div_u64(logic [63:0] a, logic [63:0] d);
        logic [63:0] q;
        logic [64:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], a[i]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // sin(pi/2 * j / QTR_SIZE) in Q2.62 by Taylor series
    function automatic logic [63:0] quarter_sin(int unsigned j);
        logic [63:0] f;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] pos;
        logic [63:0] neg;
        logic [63:0] dv;
        f    = 64'(j) << (62 - QTR_BITS);
        x    = mul_q62(HALF_PI_Q62, f);
        x2   = mul_q62(x, x);
        term = x;
        pos  = x;
        neg  = '0;
        for (int n = 1; n <= 13; n++) begin
            dv   = 64'((2 * n) * (2 * n + 1));
            term = div_u64(mul_q62(term, x2), dv);
            if (n[0]) begin
                neg = neg + term;
            end else begin
                pos = pos + term;
            end
        end
        return (pos > neg) ? (pos - neg) : 64'd0;
    endfunction

    function automatic t_qtr_tbl build_qtr_tbl();
        t_qtr_tbl    t;
        logic [63:0] s;
        logic [63:0] fl;
        logic        inx;
        for (int j = 0; j < QTR_SIZE; j++) begin
            s   = quarter_sin(j);
            fl  = s >> FRAC_SH;
            inx = |s[FRAC_SH-1:0];
            if (fl > 64'((1 << MAG_W) - 1)) begin
                fl = 64'((1 << MAG_W) - 1);
            end
            t[j] = {inx, fl[MAG_W-1:0]};
        end
        return t;
    endfunction

endpackage

FILE: hw/rtl/stbg_if.sv
// Handshake channels for tone items in and DAC samples out.
`timescale 1ns / 1ps

interface stbg_tone_if import stbg_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              func;
    logic [FREQ_W-1:0] frequency_hz;
    logic [MS_W-1:0]   duration_ms;

    modport source (output valid, func, frequency_hz, duration_ms, input ready);
    modport sink   (input valid, func, frequency_hz, duration_ms, output ready);
endinterface

interface stbg_sample_if import stbg_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [DAC_W-1:0] dac_value;
    logic             tone_active;
    logic             last_sample;

    modport source (output valid, dac_value, tone_active, last_sample, input ready);
    modport sink   (input valid, dac_value, tone_active, last_sample, output ready);
endinterface

FILE: hw/rtl/sine_tone_burst_generator_top.sv
// Tone burst generator top level: input register, phase accumulator and sample output register.
`timescale 1ns / 1ps

// Direct digital synthesis sine burst source. A start item (func 0) sets the tone: the sample
// count is 16000*duration_ms/1000, capped at 4096, the phase step is frequency_hz*2^32/16000,
// and the phase restarts at 0; it gives no result. Each tick item (func 1) gives one sample,
// taken from a quarter-wave sine table by the top 10 phase bits, with the last sample of the
// tone flagged; ticks while idle return 0 with tone_active low. One item is taken per clock
// unless a tick in the input register waits on a full, unread output register. An item is
// held in the input register and a tick's sample is then registered in the output register;
// the only limit on throughput is the sample channel's ready; a start never waits on it.
module sine_tone_burst_generator_top import stbg_pkg::*; (
    input logic          i_clk,
    input logic          i_rst_n,
    stbg_tone_if.sink    i_tone,
    stbg_sample_if.source o_sample
);

    // input register
    logic       r_in_valid;
    logic       r_in_func;
    t_tone_prep r_in_prep;

    // tone state
    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_step;
    logic [CNT_W-1:0]      r_left;
    logic [PHASE_BITS-1:0] n_phase;
    logic [PHASE_BITS-1:0] n_step;
    logic [CNT_W-1:0]      n_left;

    // output register
    logic             r_out_valid;
    logic [DAC_W-1:0] r_out_dac;
    logic             r_out_active;
    logic             r_out_last;

    logic                  adv;
    logic                  in_acc;
    logic [PHASE_BITS-1:0] new_step;
    logic [CNT_W-1:0]      new_count;
    logic [DAC_W-1:0]      lut_dac;

    stbg_tone_setup u_setup (
        .i_prep  (r_in_prep),
        .o_step  (new_step),
        .o_count (new_count)
    );

    stbg_sine_lut u_lut (
        .i_index (r_phase[PHASE_BITS-1 -: TABLE_BITS]),
        .o_dac   (lut_dac)
    );

    // a start never needs the output slot
    assign adv    = r_in_valid &&
                    (r_in_func == FUNC_START || !r_out_valid || o_sample.ready);
    assign in_acc = i_tone.valid && i_tone.ready;

    assign i_tone.ready         = !r_in_valid || adv;
    assign o_sample.valid       = r_out_valid;
    assign o_sample.dac_value   = r_out_dac;
    assign o_sample.tone_active = r_out_active;
    assign o_sample.last_sample = r_out_last;

    always_comb begin
        n_phase = r_phase;
        n_step  = r_step;
        n_left  = r_left;
        if (adv) begin
            if (r_in_func == FUNC_START) begin
                n_phase = '0;
                n_step  = new_step;
                n_left  = new_count;
            end else if (r_left != '0) begin
                n_phase = r_phase + r_step;
                n_left  = r_left - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_phase     <= '0;
            r_step      <= '0;
            r_left      <= '0;
        end else begin
            r_phase <= n_phase;
            r_step  <= n_step;
            r_left  <= n_left;

            if (in_acc) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end

            if (adv && r_in_func == FUNC_TICK) begin
                r_out_valid <= 1'b1;
            end else if (o_sample.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_in_func          <= i_tone.func;
            r_in_prep.step_int <= PHASE_BITS'(i_tone.frequency_hz) * STEP_INT_C;
            r_in_prep.frac_num <= SX_W'(i_tone.frequency_hz) * STEP_REM_C;
            r_in_prep.cnt_num  <= CY_W'(i_tone.duration_ms) * RATE_C;
        end
        if (adv && r_in_func == FUNC_TICK) begin
            r_out_dac    <= (r_left != '0) ? lut_dac : '0;
            r_out_active <= (r_left != '0);
            r_out_last   <= (r_left == CNT_W'(1));
        end
    end

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_active) |-> (r_out_dac == '0 && !r_out_last))
        else $error("idle sample not zero");

    a_last_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> r_out_active)
        else $error("last flag outside a tone");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_left <= CNT_W'(MAX_SAMPLES))
        else $error("sample count above cap");

    a_final_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_func == FUNC_TICK && r_left == CNT_W'(1))
        |=> (r_left == '0 && r_out_last && r_out_valid))
        else $error("final sample not flagged");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_func == FUNC_START) |=> (r_phase == '0))
        else $error("phase not restarted on start");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !adv) |=> (r_in_valid && $stable(r_in_func)))
        else $error("stalled item lost");

endmodule

FILE: hw/rtl/stbg_sine_lut.sv
// Quarter-wave sine lookup giving the 10-bit DAC code for a table index.
`timescale 1ns / 1ps

module stbg_sine_lut import stbg_pkg::*; (
    input  logic [TABLE_BITS-1:0] i_index,
    output logic [DAC_W-1:0]      o_dac
);

    localparam t_qtr_tbl QTR_TBL = build_qtr_tbl();

    logic [1:0]          quad;
    logic [QTR_BITS-1:0] r;
    logic [QTR_BITS-1:0] j;
    logic [QTR_W-1:0]    e;
    logic [DAC_W:0]      sum;

    always_comb begin
        quad = i_index[TABLE_BITS-1 -: 2];
        r    = i_index[QTR_BITS-1:0];
        // falling quadrants mirror the table
        j    = quad[0] ? (QTR_BITS'(0) - r) : r;
        e    = QTR_TBL[j];
        sum  = '0;
        if (r == '0) begin
            // zero crossings and peaks are exact
            o_dac = quad[0] ? (quad[1] ? '0 : DAC_MAX) : DAC_MID;
        end else begin
            if (!quad[1]) begin
                sum = (DAC_W + 1)'(DAC_MID) + (DAC_W + 1)'(e[MAG_W-1:0]);
            end else begin
                // negative half rounds the magnitude up
                sum = (DAC_W + 1)'(DAC_MID) - (DAC_W + 1)'(e[MAG_W-1:0])
                    - (DAC_W + 1)'(e[QTR_W-1]);
            end
            o_dac = (sum > (DAC_W + 1)'(DAC_MAX)) ? DAC_MAX : sum[DAC_W-1:0];
        end
    end

endmodule

FILE: hw/rtl/stbg_tone_setup.sv
// Finishes the phase step and sample count of a start item from its pre-multiplied operands.
`timescale 1ns / 1ps

module stbg_tone_setup import stbg_pkg::*; (
    input  t_tone_prep            i_prep,
    output logic [PHASE_BITS-1:0] o_step,
    output logic [CNT_W-1:0]      o_count
);

    logic [SX_W+SXM_W-1:0] frac_prod;
    logic [CY_W+CYM_W-1:0] cnt_prod;
    logic [FREQ_W-1:0]     frac;
    logic [CQ_W-1:0]       cnt;

    always_comb begin
        // divide by the sample rate and by 1000 via reciprocal multiplies
        frac_prod = {{SXM_W{1'b0}}, i_prep.frac_num} * {{SX_W{1'b0}}, SX_M_C};
        cnt_prod  = {{CYM_W{1'b0}}, i_prep.cnt_num} * {{CY_W{1'b0}}, CY_M_C};
        frac      = frac_prod[SX_S +: FREQ_W];
        cnt       = cnt_prod[CY_S +: CQ_W];
        o_step    = i_prep.step_int + PHASE_BITS'(frac);
        if (32'(cnt) > 32'(MAX_SAMPLES)) begin
            o_count = CNT_W'(MAX_SAMPLES);
        end else begin
            o_count = CNT_W'(cnt);
        end
    end

endmodule

FILE: dv/tb_sine_tone_burst_generator_top.sv
// Self-checking testbench for the sine tone burst generator top level.
`timescale 1ns / 1ps

module tb_sine_tone_burst_generator_top;
    import stbg_pkg::*;

    localparam real TWO_PI         = 6.283185307179586476925;
    localparam int  LUT_SIZE       = 1 << TABLE_BITS;
    localparam int  RX_HOLD_CYCLES = 300;
    localparam int  RANDOM_ITEMS   = 1760;
    localparam int  DRAIN_CYCLES   = 20;

    typedef struct packed {
        logic [DAC_W-1:0] dac_value;
        logic             tone_active;
        logic             last_sample;
    } t_dac_sample;

    logic i_clk;
    logic i_rst_n;

    stbg_tone_if   tone_if ();
    stbg_sample_if sample_if ();

    sine_tone_burst_generator_top DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tone   (tone_if),
        .o_sample (sample_if)
    );

    // Predicted tone state
    logic [DAC_W-1:0]      sine_lut [LUT_SIZE];
    logic [PHASE_BITS-1:0] tone_phase;
    logic [PHASE_BITS-1:0] tone_step;
    int unsigned           tone_left;
    t_dac_sample           pending_samples [$];

    int   mismatch_cnt;
    logic gaps_on;
    int   burst_left;
    logic rx_free;
    logic rx_hold_req;
    int   rx_hold_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Mismatches found");
        $finish;
    end

    // floor(512 + 512*sin), the four exact points set by hand
    task automatic build_sine_lut();
        int  quad;
        int  v;
        real s;
        for (int k = 0; k < LUT_SIZE; k++) begin
            quad = k >> (TABLE_BITS - 2);
            if ((k & ((LUT_SIZE / 4) - 1)) == 0) begin
                v = (quad == 1) ? int'(DAC_MAX) : (quad == 3) ? 0 : int'(DAC_MID);
            end else begin
                s = $sin(TWO_PI * real'(k) / real'(LUT_SIZE));
                v = int'($floor(512.0 + 512.0 * s));
                if (v > int'(DAC_MAX)) v = int'(DAC_MAX);
                if (v < 0) v = 0;
            end
            sine_lut[k] = DAC_W'(v);
        end
    endtask

    function automatic int unsigned tone_samples(logic [MS_W-1:0] ms);
        longint unsigned n;
        n = (longint'(SAMPLE_RATE) * longint'(ms)) / MS_PER_S;
        if (n > MAX_SAMPLES) n = MAX_SAMPLES;
        return int'(n);
    endfunction

    task automatic predict_dds(logic func, logic [FREQ_W-1:0] freq, logic [MS_W-1:0] ms);
        t_dac_sample     smp;
        longint unsigned wide_step;
        if (func == FUNC_START) begin
            wide_step  = (longint'(freq) << PHASE_BITS) / SAMPLE_RATE;
            tone_step  = PHASE_BITS'(wide_step);
            tone_left  = tone_samples(ms);
            tone_phase = '0;
        end else if (tone_left == 0) begin
            smp = '0;
            pending_samples.push_back(smp);
        end else begin
            smp.dac_value   = sine_lut[tone_phase[PHASE_BITS-1 -: TABLE_BITS]];
            smp.tone_active = 1'b1;
            smp.last_sample = (tone_left == 1);
            tone_phase      = tone_phase + tone_step;
            tone_left--;
            pending_samples.push_back(smp);
        end
    endtask

    // valid is left high after acceptance; a gap or a drain lowers it
    task automatic send_item(logic func, logic [FREQ_W-1:0] freq, logic [MS_W-1:0] ms);
        if (gaps_on && burst_left == 0) begin
            tone_if.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = $urandom_range(1, 20);
        end
        if (burst_left > 0) burst_left--;
        tone_if.valid        <= 1'b1;
        tone_if.func         <= func;
        tone_if.frequency_hz <= freq;
        tone_if.duration_ms  <= ms;
        @(posedge i_clk);
        while (!tone_if.ready) @(posedge i_clk);
        predict_dds(func, freq, ms);
    endtask

    task automatic send_tick();
        send_item(FUNC_TICK, FREQ_W'($urandom), MS_W'($urandom));
    endtask

    task automatic wait_drained();
        tone_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_samples.size() != 0);
    endtask

    // Receiver: random ready runs, ready held high while free, or a long counted hold-off on request
    initial begin : rx_pattern
        int   run_len;
        logic run_lvl;
        run_len = 0;
        run_lvl = 1'b0;
        sample_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req  = 1'b0;
                rx_hold_left = RX_HOLD_CYCLES;
            end
            if (rx_hold_left > 0) begin
                sample_if.ready <= 1'b0;
                rx_hold_left--;
            end else if (rx_free) begin
                sample_if.ready <= 1'b1;
            end else begin
                if (run_len == 0) begin
                    run_lvl = ~run_lvl;
                    run_len = run_lvl ? $urandom_range(1, 24) : $urandom_range(1, 6);
                end
                run_len--;
                sample_if.ready <= run_lvl;
            end
        end
    end

    always @(posedge i_clk) begin
        t_dac_sample want;
        if (i_rst_n && sample_if.valid && sample_if.ready) begin
            if (pending_samples.size() == 0) begin
                $display("%t: unexpected sample dac=%0d active=%0b last=%0b", $time,
                         sample_if.dac_value, sample_if.tone_active, sample_if.last_sample);
                mismatch_cnt++;
            end else begin
                want = pending_samples.pop_front();
                if (sample_if.dac_value !== want.dac_value) begin
                    $display("%t: dac_value expected %0d got %0d", $time,
                             want.dac_value, sample_if.dac_value);
                    mismatch_cnt++;
                end
                if (sample_if.tone_active !== want.tone_active) begin
                    $display("%t: tone_active expected %0b got %0b", $time,
                             want.tone_active, sample_if.tone_active);
                    mismatch_cnt++;
                end
                if (sample_if.last_sample !== want.last_sample) begin
                    $display("%t: last_sample expected %0b got %0b", $time,
                             want.last_sample, sample_if.last_sample);
                    mismatch_cnt++;
                end
            end
        end
    end

    task automatic test_idle_ticks();
        send_tick();
        send_tick();
    endtask

    task automatic test_tone_edges();
        // zero length leaves the block idle
        send_item(FUNC_START, '0, '0);
        send_tick();
        // full-scale fields: capped count, wrapped step
        send_item(FUNC_START, '1, '1);
        send_tick();
        send_tick();
        // quarter-rate tone walks the exact points, then a restart mid-tone
        send_item(FUNC_START, FREQ_W'(SAMPLE_RATE / 4), MS_W'(1));
        repeat (3) send_tick();
        send_item(FUNC_START, FREQ_W'(SAMPLE_RATE), MS_W'(1));
        send_tick();
        // shortest tone played out to its flagged end and one idle tick past it
        send_item(FUNC_START, FREQ_W'(SAMPLE_RATE / 2 + 1), MS_W'(1));
        repeat (tone_samples(MS_W'(1)) + 1) send_tick();
        wait_drained();
    endtask

    task automatic test_output_hold();
        gaps_on = 1'b0;
        send_item(FUNC_START, FREQ_W'(1000), MS_W'(8));
        rx_hold_req = 1'b1;
        repeat (60) send_tick();
        wait_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_bursts();
        int              sent;
        int              ticks;
        int unsigned     n_samp;
        logic [FREQ_W-1:0] freq;
        logic [MS_W-1:0]   ms;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 15) == 0) begin
                send_item(1'($urandom), FREQ_W'($urandom), MS_W'($urandom));
                sent++;
            end else begin
                freq = ($urandom_range(0, 7) == 0) ? FREQ_W'($urandom_range(0, 40))
                                                   : FREQ_W'($urandom);
                case ($urandom_range(0, 15))
                    0:       ms = MS_W'($urandom);
                    1:       ms = MS_W'($urandom_range(250, 260));
                    default: ms = MS_W'($urandom_range(0, 8));
                endcase
                n_samp = tone_samples(ms);
                if (n_samp > 160)
                    ticks = $urandom_range(1, 40);
                else if ($urandom_range(0, 7) == 0)
                    ticks = $urandom_range(0, n_samp);
                else
                    ticks = n_samp + $urandom_range(0, 3);
                send_item(FUNC_START, freq, ms);
                repeat (ticks) send_tick();
                sent += ticks + 1;
            end
            if ($urandom_range(0, 19) == 0) wait_drained();
            if ($urandom_range(0, 9) == 0) rx_free = ~rx_free;
            if ($urandom_range(0, 9) == 0) gaps_on = ~gaps_on;
        end
        rx_free = 1'b0;
    endtask

    initial begin
        mismatch_cnt = 0;
        gaps_on      = 1'b0;
        burst_left   = 0;
        rx_free      = 1'b1;
        rx_hold_req  = 1'b0;
        rx_hold_left = 0;
        tone_phase   = '0;
        tone_step    = '0;
        tone_left    = 0;
        i_rst_n              <= 1'b0;
        tone_if.valid        <= 1'b0;
        tone_if.func         <= FUNC_START;
        tone_if.frequency_hz <= '0;
        tone_if.duration_ms  <= '0;
        build_sine_lut();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_ticks();
        test_tone_edges();
        rx_free = 1'b0;
        gaps_on = 1'b1;
        test_output_hold();
        test_random_bursts();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0 && pending_samples.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/stbg_pkg.sv
hw/rtl/stbg_if.sv
hw/rtl/stbg_sine_lut.sv
hw/rtl/stbg_tone_setup.sv
hw/rtl/sine_tone_burst_generator_top.sv
dv/tb_sine_tone_burst_generator_top.sv
